// ===== sv/gjrr_pkg.sv =====
// Shared types, constants and fixed-point helpers for the Gauss-Jordan row reducer.
// Used by the channel interfaces and by the top level; depends on nothing.
package gjrr_pkg;

	localparam int DEF_MAX_ROWS = 4;
	localparam int DEF_MAX_COLS = 8;
	localparam int VAL_W        = 40;
	localparam int FRAC_W       = 24;
	localparam int CW           = 4;
	localparam int ROWS_W       = 3;
	localparam int COLS_W       = 4;
	localparam int THR_W        = 25;
	localparam int ROW_IDX_W    = 2;
	localparam int COL_IDX_W    = 3;
	localparam int CFG_IDX_W    = 8;
	localparam int CFG_DAT_W    = 25;
	localparam int QW           = 64;
	localparam int HALF_W       = 20;

	localparam logic [CFG_IDX_W-1:0] REG_ROWS = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLS = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_THR  = 8'd2;

	localparam logic [ROWS_W-1:0] ROWS_RESET = 3'd3;
	localparam logic [COLS_W-1:0] COLS_RESET = 4'd4;
	localparam logic [THR_W-1:0]  THR_RESET  = 25'd17;

	typedef logic signed [VAL_W-1:0] val_t;
	typedef logic [VAL_W-1:0]        mag_t;

	localparam logic [QW-1:0] MAG_POS_MAX = 64'h0000_007F_FFFF_FFFF;
	localparam logic [QW-1:0] MAG_NEG_MAX = 64'h0000_0080_0000_0000;
	localparam val_t VAL_MAX = 40'sh7F_FFFF_FFFF;
	localparam val_t VAL_MIN = 40'sh80_0000_0000;

	function automatic mag_t mag_of(val_t v);
		return v[VAL_W-1] ? mag_t'(-v) : mag_t'(v);
	endfunction

	// Applies a sign to a wide magnitude and clamps to the 40-bit signed range.
	function automatic val_t sat_mag(logic [QW-1:0] m, logic neg);
		val_t r;
		if (neg) begin
			if (m > MAG_NEG_MAX) r = VAL_MIN;
			else r = val_t'(-m[VAL_W-1:0]);
		end else begin
			if (m > MAG_POS_MAX) r = VAL_MAX;
			else r = val_t'(m[VAL_W-1:0]);
		end
		return r;
	endfunction

	function automatic val_t sat_diff(logic signed [VAL_W:0] d);
		val_t r;
		if (d > (VAL_W+1)'(VAL_MAX)) r = VAL_MAX;
		else if (d < (VAL_W+1)'(VAL_MIN)) r = VAL_MIN;
		else r = d[VAL_W-1:0];
		return r;
	endfunction

endpackage

// ===== sv/gjrr_elem_if.sv =====
// Input channel: one matrix element per beat.
// Depends on gjrr_pkg.
interface gjrr_elem_if import gjrr_pkg::*; ();
	logic valid;
	logic ready;
	val_t element_value;
	logic last_element;

	modport source(output valid, element_value, last_element, input ready);
	modport sink(input valid, element_value, last_element, output ready);
endinterface

// ===== sv/gjrr_res_if.sv =====
// Result channel: one reduced element, or one failure word, per beat.
// Depends on gjrr_pkg.
interface gjrr_res_if import gjrr_pkg::*; ();
	logic                 valid;
	logic                 ready;
	val_t                 result_value;
	logic [ROW_IDX_W-1:0] row_index;
	logic [COL_IDX_W-1:0] col_index;
	logic                 success;
	logic                 last_result;

	modport source(output valid, result_value, row_index, col_index, success, last_result,
		input ready);
	modport sink(input valid, result_value, row_index, col_index, success, last_result,
		output ready);
endinterface

// ===== sv/gjrr_cfg_if.sv =====
// Configuration write channel: register index and data per beat.
// Depends on gjrr_pkg.
interface gjrr_cfg_if import gjrr_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DAT_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== sv/gjrr_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
module gjrr_ram #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== sv/gauss_jordan_row_reduction.sv =====
// Gauss-Jordan reducer with partial pivoting on an n-by-m matrix of signed Q16.24 values.
// Elements load row-major, one per beat; the beat marked last starts the run. Loading
// accepts one element per cycle. A run then, per pivot row, searches the rows at and below
// it for the pivot, swaps the pivot row column by column, divides each column from the
// pivot on (a 64-step bit-serial divider), and eliminates every other row element by element
// (one read port of the matrix RAM and a 40x20 multiplier used twice), after which the
// result beats go out. No input beat is taken from the last element until the final result beat is taken.
// Depends on gjrr_pkg, the three channel interfaces and gjrr_ram.
module gauss_jordan_row_reduction import gjrr_pkg::*; #(
	parameter int MAX_ROWS = DEF_MAX_ROWS,
	parameter int MAX_COLS = DEF_MAX_COLS
) (
	input  logic         clk,
	input  logic         arst_n,
	gjrr_elem_if.sink    elem,
	gjrr_res_if.source   res,
	gjrr_cfg_if.sink     cfg
);
	localparam int DEPTH  = MAX_ROWS * MAX_COLS;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int PW     = ADDR_W + 1;

	typedef enum logic [4:0] {
		S_IDLE, S_START, S_PV_RD, S_PV_CAP, S_PV_CHK,
		S_SW_RDA, S_SW_RDB, S_SW_WR1, S_SW_WR2,
		S_DV_RD, S_DV_LD, S_DV_RUN, S_DV_WR,
		S_NXT, S_EL_F, S_EL_FC, S_EL_RS, S_EL_RT, S_EL_M1, S_EL_M2, S_EL_WR,
		S_FAIL, S_OUT, S_O_RD, S_O_CAP, S_O_WAIT
	} state_t;

	state_t state_q;

	logic [ROWS_W-1:0] rows_q;
	logic [COLS_W-1:0] cols_q;
	logic [THR_W-1:0]  thr_q;

	logic [CW-1:0] n_live, m_live, n_q, m_q;
	logic [CW-1:0] i_q, j_q, r_q, l_q, best_q;
	logic          phase_q;
	logic [PW-1:0] pos_q;
	logic [2*CW-1:0] nm_live;

	val_t piv_q, a_q, f_q, b_q, t_q;
	mag_t best_mag_q;
	logic [2*HALF_W+HALF_W-1:0] pl_q, ph_q;

	logic [VAL_W-1:0] rem_q;
	logic [QW-1:0]    dvd_q, quo_q;
	logic [6:0]       cnt_q;
	logic             dneg_q;

	logic               wr_en;
	logic [ADDR_W-1:0]  wr_addr, rd_addr;
	val_t               wr_data, rd_data;

	logic              out_valid_q, out_succ_q, out_last_q;
	val_t              out_val_q;
	logic [ROW_IDX_W-1:0] out_row_q;
	logic [COL_IDX_W-1:0] out_col_q;

	logic elem_acc;
	mag_t rd_mag, ua, ub;
	logic [VAL_W:0] rem_sh, rem_try;
	logic [QW-1:0]  prod_mag;
	val_t           prod_val;

	function automatic logic [ADDR_W-1:0] addr_of(logic [CW-1:0] r, logic [CW-1:0] c,
		logic [CW-1:0] m);
		logic [2*CW-1:0] a;
		a = (2*CW)'(r) * (2*CW)'(m) + (2*CW)'(c);
		return a[ADDR_W-1:0];
	endfunction

	// Out-of-range register values are pulled into the supported range.
	always_comb begin
		n_live = CW'(rows_q);
		if (rows_q == '0) n_live = CW'(1);
		else if (CW'(rows_q) > CW'(MAX_ROWS)) n_live = CW'(MAX_ROWS);
		m_live = CW'(cols_q);
		if (cols_q == '0) m_live = CW'(1);
		else if (CW'(cols_q) > CW'(MAX_COLS)) m_live = CW'(MAX_COLS);
		nm_live = (2*CW)'(n_live) * (2*CW)'(m_live);
	end

	assign elem.ready = (state_q == S_IDLE);
	assign elem_acc   = elem.valid && elem.ready;
	assign cfg.ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= ROWS_RESET;
			cols_q <= COLS_RESET;
			thr_q  <= THR_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_ROWS: rows_q <= cfg.data[ROWS_W-1:0];
				REG_COLS: cols_q <= cfg.data[COLS_W-1:0];
				REG_THR:  thr_q  <= cfg.data[THR_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (elem_acc) begin
			if (elem.last_element) pos_q <= '0;
			else if ((2*CW)'(pos_q) < nm_live) pos_q <= pos_q + PW'(1);
		end
	end

	gjrr_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH), .AW(ADDR_W)) u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	assign rd_mag = mag_of(rd_data);
	assign ua     = mag_of(f_q);
	assign ub     = mag_of(b_q);

	// Product magnitude is (ua*hi*2^20 + ua*lo) >> 24, built from the two partial products.
	assign prod_mag = QW'((ph_q + (pl_q >> HALF_W)) >> (FRAC_W - HALF_W));
	assign prod_val = sat_mag(prod_mag, f_q[VAL_W-1] ^ b_q[VAL_W-1]);

	assign rem_sh  = {rem_q, dvd_q[QW-1]};
	assign rem_try = rem_sh - {1'b0, mag_of(piv_q)};

	always_comb begin
		rd_addr = addr_of(i_q, l_q, m_q);
		wr_en   = 1'b0;
		wr_addr = addr_of(i_q, l_q, m_q);
		wr_data = rd_data;
		case (state_q)
			S_IDLE: begin
				wr_en   = elem_acc && ((2*CW)'(pos_q) < nm_live);
				wr_addr = pos_q[ADDR_W-1:0];
				wr_data = elem.element_value;
			end
			S_PV_RD:  rd_addr = addr_of(j_q, i_q, m_q);
			S_SW_RDB: rd_addr = addr_of(best_q, l_q, m_q);
			S_SW_WR1: wr_en = 1'b1;
			S_SW_WR2: begin
				wr_en   = 1'b1;
				wr_addr = addr_of(best_q, l_q, m_q);
				wr_data = a_q;
			end
			S_DV_WR: begin
				wr_en   = 1'b1;
				wr_data = sat_mag(quo_q, dneg_q);
			end
			S_EL_F:  rd_addr = addr_of(r_q, i_q, m_q);
			S_EL_RT: rd_addr = addr_of(r_q, l_q, m_q);
			S_EL_WR: begin
				wr_en   = 1'b1;
				wr_addr = addr_of(r_q, l_q, m_q);
				wr_data = sat_diff({t_q[VAL_W-1], t_q} - {prod_val[VAL_W-1], prod_val});
			end
			S_O_RD:  rd_addr = addr_of(r_q, l_q, m_q);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			out_last_q  <= 1'b0;
			n_q <= '0; m_q <= '0; i_q <= '0; j_q <= '0; r_q <= '0; l_q <= '0;
			best_q <= '0; phase_q <= 1'b0; cnt_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (elem_acc && elem.last_element) begin
						n_q     <= n_live;
						m_q     <= m_live;
						state_q <= S_START;
					end
				end
				S_START: begin
					phase_q <= 1'b0;
					i_q     <= '0;
					j_q     <= '0;
					state_q <= (m_q < n_q) ? S_FAIL : S_PV_RD;
				end
				S_PV_RD: state_q <= S_PV_CAP;
				S_PV_CAP: begin
					// Strict compare keeps the topmost row on ties.
					if (j_q == i_q || rd_mag > best_mag_q) begin
						best_q     <= j_q;
						best_mag_q <= rd_mag;
						piv_q      <= rd_data;
					end
					if ((j_q + CW'(1)) < n_q) begin
						j_q     <= j_q + CW'(1);
						state_q <= S_PV_RD;
					end else begin
						state_q <= S_PV_CHK;
					end
				end
				S_PV_CHK: begin
					if (piv_q == '0 || best_mag_q < VAL_W'(thr_q)) begin
						state_q <= S_FAIL;
					end else if (best_q != i_q) begin
						l_q     <= '0;
						state_q <= S_SW_RDA;
					end else begin
						l_q     <= i_q;
						state_q <= S_DV_RD;
					end
				end
				S_SW_RDA: state_q <= S_SW_RDB;
				S_SW_RDB: begin
					a_q     <= rd_data;
					state_q <= S_SW_WR1;
				end
				S_SW_WR1: state_q <= S_SW_WR2;
				S_SW_WR2: begin
					if ((l_q + CW'(1)) < m_q) begin
						l_q     <= l_q + CW'(1);
						state_q <= S_SW_RDA;
					end else begin
						l_q     <= i_q;
						state_q <= S_DV_RD;
					end
				end
				S_DV_RD: state_q <= S_DV_LD;
				S_DV_LD: begin
					rem_q   <= '0;
					dvd_q   <= QW'(mag_of(rd_data)) << FRAC_W;
					quo_q   <= '0;
					dneg_q  <= rd_data[VAL_W-1] ^ piv_q[VAL_W-1];
					cnt_q   <= '0;
					state_q <= S_DV_RUN;
				end
				S_DV_RUN: begin
					// One restoring step per cycle; the remainder stays below the divisor.
					if (!rem_try[VAL_W]) begin
						rem_q <= rem_try[VAL_W-1:0];
						quo_q <= {quo_q[QW-2:0], 1'b1};
					end else begin
						rem_q <= rem_sh[VAL_W-1:0];
						quo_q <= {quo_q[QW-2:0], 1'b0};
					end
					dvd_q <= {dvd_q[QW-2:0], 1'b0};
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'(QW - 1)) state_q <= S_DV_WR;
				end
				S_DV_WR: begin
					if ((l_q + CW'(1)) < m_q) begin
						l_q     <= l_q + CW'(1);
						state_q <= S_DV_RD;
					end else begin
						r_q     <= i_q;
						state_q <= S_NXT;
					end
				end
				S_NXT: begin
					if (!phase_q) begin
						if ((r_q + CW'(1)) < n_q) begin
							r_q     <= r_q + CW'(1);
							state_q <= S_EL_F;
						end else if ((i_q + CW'(1)) < n_q) begin
							i_q     <= i_q + CW'(1);
							j_q     <= i_q + CW'(1);
							state_q <= S_PV_RD;
						end else begin
							// Forward pass done; clear the rows above each pivot, bottom up.
							phase_q <= 1'b1;
							i_q     <= n_q - CW'(1);
							r_q     <= n_q - CW'(1);
						end
					end else begin
						if (r_q != '0) begin
							r_q     <= r_q - CW'(1);
							state_q <= S_EL_F;
						end else if (i_q > CW'(1)) begin
							i_q     <= i_q - CW'(1);
							r_q     <= i_q - CW'(2);
							state_q <= S_EL_F;
						end else begin
							state_q <= S_OUT;
						end
					end
				end
				S_EL_F: state_q <= S_EL_FC;
				S_EL_FC: begin
					f_q     <= rd_data;
					l_q     <= i_q;
					state_q <= S_EL_RS;
				end
				S_EL_RS: state_q <= S_EL_RT;
				S_EL_RT: begin
					b_q     <= rd_data;
					state_q <= S_EL_M1;
				end
				S_EL_M1: begin
					t_q     <= rd_data;
					pl_q    <= ua * ub[HALF_W-1:0];
					state_q <= S_EL_M2;
				end
				S_EL_M2: begin
					ph_q    <= ua * ub[2*HALF_W-1:HALF_W];
					state_q <= S_EL_WR;
				end
				S_EL_WR: begin
					if ((l_q + CW'(1)) < m_q) begin
						l_q     <= l_q + CW'(1);
						state_q <= S_EL_RS;
					end else begin
						state_q <= S_NXT;
					end
				end
				S_FAIL: begin
					out_val_q   <= '0;
					out_row_q   <= '0;
					out_col_q   <= '0;
					out_succ_q  <= 1'b0;
					out_last_q  <= 1'b1;
					out_valid_q <= 1'b1;
					state_q     <= S_O_WAIT;
				end
				S_OUT: begin
					r_q     <= '0;
					l_q     <= '0;
					state_q <= S_O_RD;
				end
				S_O_RD: state_q <= S_O_CAP;
				S_O_CAP: begin
					out_val_q   <= rd_data;
					out_row_q   <= r_q[ROW_IDX_W-1:0];
					out_col_q   <= l_q[COL_IDX_W-1:0];
					out_succ_q  <= 1'b1;
					out_last_q  <= ((r_q + CW'(1)) == n_q) && ((l_q + CW'(1)) == m_q);
					out_valid_q <= 1'b1;
					state_q     <= S_O_WAIT;
				end
				S_O_WAIT: begin
					if (res.ready) begin
						out_valid_q <= 1'b0;
						if (out_last_q) begin
							state_q <= S_IDLE;
						end else begin
							if ((l_q + CW'(1)) < m_q) begin
								l_q <= l_q + CW'(1);
							end else begin
								l_q <= '0;
								r_q <= r_q + CW'(1);
							end
							state_q <= S_O_RD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign res.valid        = out_valid_q;
	assign res.result_value = out_val_q;
	assign res.row_index    = out_row_q;
	assign res.col_index    = out_col_q;
	assign res.success      = out_succ_q;
	assign res.last_result  = out_last_q;

	// A result beat is only ever presented from the output wait state.
	assert property (@(posedge clk) disable iff (!arst_n) res.valid |-> state_q == S_O_WAIT)
		else $error("result valid outside output wait");

	// While loading, the store is written only on an accepted element beat.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && wr_en) |-> elem_acc)
		else $error("store write without accepted element");

	// The load position never runs past the store.
	assert property (@(posedge clk) disable iff (!arst_n) pos_q <= PW'(DEPTH))
		else $error("load position beyond store depth");

	// A failure beat is always the last beat of its run.
	assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.success) |-> res.last_result)
		else $error("failure beat not marked last");
endmodule
